FILE: rtl/core/vtpg_pkg.sv
`timescale 1ns / 1ps

package vtpg_pkg;

    // Coordinate and register widths
    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 13;
    localparam int TH_W       = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int HALF_DIM_W = DIM_W - 1;
    localparam int SQ_W       = 2 * HALF_DIM_W;
    localparam int DD_W       = SQ_W + 1;

    // Divider lanes: bar quotient, column remainder, row remainder
    localparam int DIV_LANES  = 3;
    localparam int DVD_W      = 15;
    localparam int DVS_W      = 13;
    localparam int DIV_STAGES = DVD_W;
    localparam int LANE_BAR   = 0;
    localparam int LANE_GX    = 1;
    localparam int LANE_GY    = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [TH_W-1:0]  BORDER_RST = 8'd4;

    typedef logic [DVD_W-1:0] t_dvd;
    typedef logic [DVS_W-1:0] t_dvs;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Classification that travels beside the divider
    typedef struct packed {
        logic border;
        logic inner;
        logic outer;
        logic num_neg;
    } t_side;

    typedef struct packed {
        logic       ge;
        logic [DVS_W-1:0] rem;
    } t_step;

    localparam t_rgb RGB_GREEN = '{8'd0, 8'd255, 8'd0};
    localparam t_rgb RGB_GREY  = '{8'd127, 8'd127, 8'd127};
    localparam t_rgb RGB_WHITE = '{8'd255, 8'd255, 8'd255};
    localparam t_rgb RGB_RED   = '{8'd255, 8'd0, 8'd0};
    localparam t_rgb RGB_BLACK = '{8'd0, 8'd0, 8'd0};

    // Eight vertical color bars
    function automatic t_rgb bar_color(input logic [2:0] idx);
        t_rgb c;
        case (idx)
            3'd0:    c = RGB_WHITE;
            3'd1:    c = '{8'd255, 8'd255, 8'd0};
            3'd2:    c = '{8'd0, 8'd255, 8'd255};
            3'd3:    c = RGB_GREEN;
            3'd4:    c = '{8'd255, 8'd0, 8'd255};
            3'd5:    c = RGB_RED;
            3'd6:    c = '{8'd0, 8'd0, 8'd255};
            default: c = RGB_BLACK;
        endcase
        return c;
    endfunction

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic t_step div_step(input t_dvs rem, input logic nbit, input t_dvs dvs);
        logic [DVS_W:0] trial;
        logic [DVS_W:0] diff;
        t_step          s;
        trial = {rem, nbit};
        diff  = trial - {1'b0, dvs};
        s.ge  = (trial >= {1'b0, dvs});
        s.rem = s.ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        return s;
    endfunction

endpackage

FILE: rtl/core/vtpg_divider.sv
`timescale 1ns / 1ps

module vtpg_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vtpg_pkg::t_side i_side,
    input  vtpg_pkg::t_dvd i_dvd [vtpg_pkg::DIV_LANES],
    input  vtpg_pkg::t_dvs i_dvs [vtpg_pkg::DIV_LANES],
    output logic           o_valid,
    output vtpg_pkg::t_side o_side,
    output vtpg_pkg::t_dvd o_quo [vtpg_pkg::DIV_LANES],
    output vtpg_pkg::t_dvs o_rem [vtpg_pkg::DIV_LANES]
);
    import vtpg_pkg::*;

    // One quotient bit per stage in every lane.
    genvar k, l;
    generate
        for (k = 1; k <= DIV_STAGES; k++) begin : g_stage
            logic  src_valid;
            t_side src_side;
            logic  r_valid;
            t_side r_side;

            if (k == 1) begin : g_first
                assign src_valid = i_valid;
                assign src_side  = i_side;
            end else begin : g_next
                assign src_valid = g_stage[k-1].r_valid;
                assign src_side  = g_stage[k-1].r_side;
            end

            // Valid bit of this stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else begin
                    r_valid <= src_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                r_side <= src_side;
            end

            for (l = 0; l < DIV_LANES; l++) begin : g_lane
                t_dvd  src_num;
                t_dvs  src_dvs;
                t_dvs  src_rem;
                t_dvd  src_quo;
                t_step n_step;
                t_dvd  r_num;
                t_dvs  r_dvs;
                t_dvs  r_rem;
                t_dvd  r_quo;

                if (k == 1) begin : g_first
                    assign src_num = i_dvd[l];
                    assign src_dvs = i_dvs[l];
                    assign src_rem = '0;
                    assign src_quo = '0;
                end else begin : g_next
                    assign src_num = g_stage[k-1].g_lane[l].r_num;
                    assign src_dvs = g_stage[k-1].g_lane[l].r_dvs;
                    assign src_rem = g_stage[k-1].g_lane[l].r_rem;
                    assign src_quo = g_stage[k-1].g_lane[l].r_quo;
                end

                assign n_step = div_step(src_rem, src_num[DVD_W-1], src_dvs);

                // Quotient bit and partial remainder
                always_ff @(posedge i_clk) begin
                    r_num <= {src_num[DVD_W-2:0], 1'b0};
                    r_dvs <= src_dvs;
                    r_rem <= n_step.rem;
                    r_quo <= {src_quo[DVD_W-2:0], n_step.ge};
                end
            end
        end

        for (l = 0; l < DIV_LANES; l++) begin : g_out
            assign o_quo[l] = g_stage[DIV_STAGES].g_lane[l].r_quo;
            assign o_rem[l] = g_stage[DIV_STAGES].g_lane[l].r_rem;
        end
    endgenerate

    assign o_valid = g_stage[DIV_STAGES].r_valid;
    assign o_side  = g_stage[DIV_STAGES].r_side;

    t_dvs last_dvs_bar;
    t_dvs last_dvs_gx;

    assign last_dvs_bar = g_stage[DIV_STAGES].g_lane[LANE_BAR].r_dvs;
    assign last_dvs_gx  = g_stage[DIV_STAGES].g_lane[LANE_GX].r_dvs;

    // The bar and column remainders of a finished request always lie below a nonzero divisor.
    a_rem_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && last_dvs_bar != '0) |->
        (o_rem[LANE_BAR] < last_dvs_bar))
        else $error("bar remainder not below divisor");

    a_rem_gx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && last_dvs_gx != '0) |->
        (o_rem[LANE_GX] < last_dvs_gx))
        else $error("grid remainder not below divisor");

endmodule

FILE: rtl/core/video_test_pattern_generator_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// request   | i_pixel_x, i_pixel_y                    | i_start high, o_busy low
// result    | o_red, o_green, o_blue                  | o_valid strobe, one cycle
// config    | i_wr_en, i_wr_addr, i_wr_data           | i_wr_en high, no wait
//
// One request enters every clock while o_busy is low; o_valid rises once the
// request has passed three front stages, a 15-stage restoring divider (one
// quotient bit per stage) and the color output register.
// Reset is synchronous; o_busy stays high after reset and after every register
// write while the derived screen geometry registers settle. The receiver cannot
// stall, so the pipeline never holds.

module video_test_pattern_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [vtpg_pkg::COORD_BITS-1:0]  i_pixel_x,
    input  logic [vtpg_pkg::COORD_BITS-1:0]  i_pixel_y,
    input  logic                             i_wr_en,
    input  logic [vtpg_pkg::CFG_ADDR_W-1:0]  i_wr_addr,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output logic                             o_valid,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue
);
    import vtpg_pkg::*;

    // Configuration registers
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [TH_W-1:0]  r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_th     <= BORDER_RST;
        end else if (i_wr_en) begin
            case (i_wr_addr)
                REG_WIDTH:  r_width  <= i_wr_data;
                REG_HEIGHT: r_height <= i_wr_data;
                REG_BORDER: r_th     <= i_wr_data[TH_W-1:0];
                default:    ;
            endcase
        end
    end

    // Derived geometry, refreshed every cycle from the registers
    logic [HALF_DIM_W-1:0] r_cx, r_cy, r_rout, r_rin_abs;
    logic [HALF_DIM_W-2:0] r_half;
    logic [SQ_W-1:0]       r_rout_sq, r_rin_sq;
    logic [DIM_W:0]        r_wlim, r_hlim;
    logic [HALF_DIM_W-1:0] n_rout;
    logic [DIM_W:0]        n_rin;

    assign n_rout = (r_width[DIM_W-1:1] > r_height[DIM_W-1:1]) ?
                    r_height[DIM_W-1:1] : r_width[DIM_W-1:1];
    assign n_rin  = {2'b00, n_rout} - {5'b0, r_th, 1'b0};

    always_ff @(posedge i_clk) begin
        r_cx      <= r_width[DIM_W-1:1];
        r_cy      <= r_height[DIM_W-1:1];
        r_rout    <= n_rout;
        r_half    <= n_rout[HALF_DIM_W-1:1];
        r_rin_abs <= n_rin[DIM_W] ? HALF_DIM_W'(-n_rin) : n_rin[HALF_DIM_W-1:0];
        r_wlim    <= {1'b0, r_width} - {6'b0, r_th};
        r_hlim    <= {1'b0, r_height} - {6'b0, r_th};
        r_rout_sq <= r_rout * r_rout;
        r_rin_sq  <= r_rin_abs * r_rin_abs;
    end

    // Busy while geometry settles after reset or a register write
    logic [1:0] r_init;
    logic       r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_busy <= 1'b1;
        end else if (i_wr_en) begin
            r_init <= '0;
            r_busy <= 1'b1;
        end else begin
            if (r_init != 2'd3) begin
                r_init <= r_init + 2'd1;
            end
            r_busy <= (r_init != 2'd3);
        end
    end

    assign o_busy = r_busy;

    // Stage 1: border test, offsets from center and bar numerator
    logic                  n_s1_valid;
    logic                  n_border;
    logic [DIM_W-1:0]      n_dx, n_dy;
    logic [DVD_W-1:0]      n_m;
    logic                  r_s1_valid, r_s1_border, r_s1_neg;
    logic [HALF_DIM_W-1:0] r_s1_adx, r_s1_ady;
    logic [DIM_W-1:0]      r_s1_am;

    assign n_s1_valid = i_start && !r_busy;
    assign n_border = ({1'b0, i_pixel_x} < {1'b0, r_th[TH_W-1:0]} ? 1'b1 : 1'b0) |
                      ({1'b0, i_pixel_y} < {1'b0, r_th[TH_W-1:0]} ? 1'b1 : 1'b0) |
                      ($signed({3'b0, i_pixel_x}) >= $signed(r_wlim)) |
                      ($signed({3'b0, i_pixel_y}) >= $signed(r_hlim));
    assign n_dx = {1'b0, i_pixel_x} - {1'b0, r_cx} + DIM_W'(i_pixel_x < r_cx);
    assign n_dy = {1'b0, i_pixel_y} - {1'b0, r_cy} + DIM_W'(i_pixel_y < r_cy);
    assign n_m  = {3'b0, i_pixel_x} - {3'b0, r_cx} + {3'b0, r_rout} + DVD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_border <= n_border;
        r_s1_adx    <= n_dx[DIM_W-1] ? HALF_DIM_W'(-n_dx) : n_dx[HALF_DIM_W-1:0];
        r_s1_ady    <= n_dy[DIM_W-1] ? HALF_DIM_W'(-n_dy) : n_dy[HALF_DIM_W-1:0];
        r_s1_neg    <= n_m[DVD_W-1];
        r_s1_am     <= n_m[DVD_W-1] ? DIM_W'(-n_m) : n_m[DIM_W-1:0];
    end

    // Stage 2: squared offsets
    logic                  r_s2_valid, r_s2_border, r_s2_neg;
    logic [SQ_W-1:0]       r_s2_dx2, r_s2_dy2;
    logic [HALF_DIM_W-1:0] r_s2_adx, r_s2_ady;
    logic [DIM_W-1:0]      r_s2_am;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_border <= r_s1_border;
        r_s2_neg    <= r_s1_neg;
        r_s2_dx2    <= r_s1_adx * r_s1_adx;
        r_s2_dy2    <= r_s1_ady * r_s1_ady;
        r_s2_adx    <= r_s1_adx;
        r_s2_ady    <= r_s1_ady;
        r_s2_am     <= r_s1_am;
    end

    // Stage 3: distance against the two radii
    logic [DD_W-1:0]       n_dd;
    logic                  r_s3_valid;
    t_side                 r_s3_side;
    logic [HALF_DIM_W-1:0] r_s3_adx, r_s3_ady;
    logic [DIM_W-1:0]      r_s3_am;

    assign n_dd = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side.border  <= r_s2_border;
        r_s3_side.inner   <= n_dd < {1'b0, r_rin_sq};
        r_s3_side.outer   <= n_dd < {1'b0, r_rout_sq};
        r_s3_side.num_neg <= r_s2_neg;
        r_s3_adx          <= r_s2_adx;
        r_s3_ady          <= r_s2_ady;
        r_s3_am           <= r_s2_am;
    end

    // Divider: bar quotient and both grid remainders
    t_dvd  dv_dvd [DIV_LANES];
    t_dvs  dv_dvs [DIV_LANES];
    t_dvd  dv_quo [DIV_LANES];
    t_dvs  dv_rem [DIV_LANES];
    logic  dv_valid;
    t_side dv_side;

    assign dv_dvd[LANE_BAR] = {r_s3_am, 2'b00};
    assign dv_dvs[LANE_BAR] = {1'b0, r_rout} + DVS_W'(1);
    assign dv_dvd[LANE_GX]  = {3'b0, r_s3_adx};
    assign dv_dvs[LANE_GX]  = {2'b0, r_half};
    assign dv_dvd[LANE_GY]  = {3'b0, r_s3_ady};
    assign dv_dvs[LANE_GY]  = {2'b0, r_half};

    vtpg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_side  (r_s3_side),
        .i_dvd   (dv_dvd),
        .i_dvs   (dv_dvs),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem)
    );

    // Color selection and output register
    logic [2:0] n_bar;
    logic       n_grid;
    t_rgb       n_rgb;
    t_rgb       r_rgb;
    logic       r_valid;

    assign n_bar  = dv_side.num_neg ? 3'(~dv_quo[LANE_BAR][2:0] + 3'd1) :
                    dv_quo[LANE_BAR][2:0];
    assign n_grid = (r_half != '0) &&
                    ((dv_rem[LANE_GX] < {5'b0, r_th}) || (dv_rem[LANE_GY] < {5'b0, r_th}));

    always_comb begin
        if (dv_side.border) begin
            n_rgb = RGB_GREEN;
        end else if (dv_side.inner) begin
            n_rgb = bar_color(n_bar);
        end else if (dv_side.outer) begin
            n_rgb = n_bar[0] ? RGB_WHITE : RGB_GREY;
        end else if (n_grid) begin
            n_rgb = RGB_RED;
        end else begin
            n_rgb = RGB_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_red   = r_rgb.red;
    assign o_green = r_rgb.green;
    assign o_blue  = r_rgb.blue;

    // A border request always leaves as green.
    a_border_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_valid && dv_side.border) |=> (o_red == 8'd0 && o_green == 8'd255 && o_blue == 8'd0))
        else $error("border pixel not green");

    // Every request leaving the divider is strobed out the next cycle.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_valid |=> o_valid)
        else $error("result strobe lost");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !dv_valid |=> !o_valid)
        else $error("result strobe without request");

    // No request is taken while geometry is still settling.
    a_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_s1_valid)
        else $error("request taken while busy");

endmodule
